// ===== sv/ugac_pkg.sv =====
`default_nettype none
package ugac_pkg;

    // Field widths fixed by the interface.
    localparam int ID_W  = 6;
    localparam int CS_W  = 12;
    localparam int DIM_W = 9;
    localparam int RC_W  = 8;

    // Operation codes.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_CHECK  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [1:0] CFG_GRID_ROWS = 2'd2;

    // What the cell walk is doing.
    localparam logic [1:0] PH_REM = 2'd0;
    localparam logic [1:0] PH_CHK = 2'd1;
    localparam logic [1:0] PH_REG = 2'd2;

    typedef struct packed {
        logic box;
        logic cnt;
        logic mem;
    } ugac_we_t;

endpackage
`default_nettype wire

// ===== sv/ugac_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ugac_div
    import ugac_pkg::*;
#(
    parameter int DVD_W = 13
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [CS_W-1:0]  divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CS_W-1:0]  rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CS_W:0]    trial;
    logic             take;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign take  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= take ? CS_W'(trial - {1'b0, divisor}) : trial[CS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== sv/ugac_store.sv =====
`default_nettype none
// Object boxes, per-cell member counts and per-cell member slots.
module ugac_store
    import ugac_pkg::*;
#(
    parameter int BOX_W  = 49,
    parameter int OBJ_W  = 6,
    parameter int CELL_W = 8,
    parameter int SLOT_W = 3,
    parameter int CNT_W  = 4
) (
    input  wire logic                     aclk,
    input  wire ugac_we_t                 we,
    input  wire logic [OBJ_W-1:0]         box_waddr,
    input  wire logic [BOX_W-1:0]         box_wdata,
    input  wire logic [OBJ_W-1:0]         box_raddr,
    output logic [BOX_W-1:0]              box_rdata,
    input  wire logic [CELL_W-1:0]        cnt_waddr,
    input  wire logic [CNT_W-1:0]         cnt_wdata,
    input  wire logic [CELL_W-1:0]        cnt_raddr,
    output logic [CNT_W-1:0]              cnt_rdata,
    input  wire logic [CELL_W+SLOT_W-1:0] mem_waddr,
    input  wire logic [ID_W-1:0]          mem_wdata,
    input  wire logic [CELL_W+SLOT_W-1:0] mem_raddr,
    output logic [ID_W-1:0]               mem_rdata
);
    logic [BOX_W-1:0] box_mem [2**OBJ_W];
    logic [CNT_W-1:0] cnt_mem [2**CELL_W];
    logic [ID_W-1:0]  mbr_mem [2**(CELL_W+SLOT_W)];

    always_ff @(posedge aclk) begin
        if (we.box) begin
            box_mem[box_waddr] <= box_wdata;
        end
        box_rdata <= box_mem[box_raddr];
    end

    always_ff @(posedge aclk) begin
        if (we.cnt) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (we.mem) begin
            mbr_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mbr_mem[mem_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/uniform_grid_aabb_collision.sv =====
`default_nettype none
// Broad-phase collision grid for axis-aligned boxes.
// The input channel (s_valid/s_ready) takes one item: an operation code, an
// object id and a box. Add stores the box and enters the id in every grid cell
// the box covers, update removes it first, remove takes the id out of all
// cells, and check looks for a strict overlap with any other id in its cells.
// The result channel (m_valid/m_ready) returns exactly one item per input item
// with the echoed id, the hit flag and a status code.
// One item is processed at a time. Remove, update and check sweep every grid
// cell and read the slots of each occupied cell, and check reads the box of
// each other member it compares. Add runs four divisions in one shared
// divider, then visits each covered cell.
// The stored state lives in three memories with registered reads; the cell
// walk is bound by their single read ports.
// After reset the block clears the object table and the cell counts with
// s_ready low. Configuration writes are taken at any time. A finished result
// waits in the output register while the receiver stalls; the next item is
// still accepted and processed, and its result waits until the output
// register has drained.
module uniform_grid_aabb_collision
    import ugac_pkg::*;
#(
    parameter int MAX_OBJECTS = 64,
    parameter int GRID_CELLS  = 256,
    parameter int CELL_SLOTS  = 8,
    parameter int COORD_BITS  = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CS_W-1:0]       cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_mode,
    input  wire logic [ID_W-1:0]       s_obj_id,
    input  wire logic [COORD_BITS-1:0] s_pos_x,
    input  wire logic [COORD_BITS-1:0] s_pos_y,
    input  wire logic [COORD_BITS-1:0] s_size_x,
    input  wire logic [COORD_BITS-1:0] s_size_y,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [ID_W-1:0]            m_result_id,
    output logic                       m_hit,
    output logic [1:0]                 m_status
);
    localparam int CB     = COORD_BITS;
    localparam int QW     = CB + 1;
    localparam int BOX_W  = 4 * CB + 1;
    localparam int OBJ_W  = $clog2(MAX_OBJECTS);
    localparam int CELL_W = $clog2(GRID_CELLS);
    localparam int SLOT_W = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
    localparam int CNT_W  = $clog2(CELL_SLOTS + 1);
    localparam int CLR_N  = (GRID_CELLS > MAX_OBJECTS) ? GRID_CELLS : MAX_OBJECTS;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int NUM_W  = 2 * RC_W + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_CNT   = 4'd3;
    localparam logic [3:0] S_CNTD  = 4'd4;
    localparam logic [3:0] S_FIND  = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_MEM   = 4'd7;
    localparam logic [3:0] S_BOX   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DIVW  = 4'd10;
    localparam logic [3:0] S_CELL  = 4'd11;
    localparam logic [3:0] S_RANGE = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    // Configuration registers.
    logic [CS_W-1:0]  cell_size_reg;
    logic [DIM_W-1:0] grid_cols_reg;
    logic [DIM_W-1:0] grid_rows_reg;

    // Control state.
    logic [3:0]       state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic             m_valid_reg, m_valid_next;

    // Working registers of one item.
    logic [1:0]        mode_reg, mode_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [4*CB-1:0]   nb_reg, nb_next;
    logic [4*CB-1:0]   own_reg, own_next;
    logic [1:0]        ph_reg, ph_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              hit_reg, hit_next;
    logic [1:0]        stat_reg, stat_next;
    logic              drop_reg, drop_next;
    logic [1:0]        dsel_reg, dsel_next;
    logic [RC_W-1:0]   sc_reg, sc_next, ec_reg, ec_next;
    logic [RC_W-1:0]   sr_reg, sr_next, er_reg, er_next;
    logic [RC_W-1:0]   r_reg, r_next, c_reg, c_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [ID_W-1:0]   m_id_reg, m_id_next;
    logic              m_hit_reg, m_hit_next;
    logic [1:0]        m_stat_reg, m_stat_next;

    // Memory ports.
    ugac_we_t                 we;
    logic [OBJ_W-1:0]         box_waddr, box_raddr;
    logic [BOX_W-1:0]         box_wdata, box_rdata;
    logic [CNT_W-1:0]         cnt_wdata, cnt_rdata;
    logic [CELL_W+SLOT_W-1:0] mem_waddr, mem_raddr;
    logic [ID_W-1:0]          mem_wdata, mem_rdata;
    logic [SLOT_W-1:0]        rd_slot;
    logic                     oth_sel;

    // Divider.
    logic             div_start, div_done;
    logic [QW-1:0]    div_dvd, div_quo;
    logic [CS_W-1:0]  div_dvs;

    // Derived values.
    logic [OBJ_W+ID_W-1:0] s_id_ext, id_ext, oth_ext;
    logic                  s_id_ok, oth_ok;
    logic [DIM_W-1:0]      cols_eff, rows_eff;
    logic [CNT_W:0]        k_p1, k_p2, cnt_x;
    logic [CB-1:0]         ax, ay, aw, ah, bx, by, bw, bh;
    logic                  ovl;
    logic                  nf, pl, nc, adv;
    logic [CNT_W-1:0]      place_cnt;
    logic [RC_W-1:0]       q_clamped;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] top;
        top = DIM_W'(256);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (v > top) begin
            return top;
        end
        return v;
    endfunction

    function automatic logic [RC_W-1:0] clamp_idx(input logic [QW-1:0] q,
                                                  input logic [DIM_W-1:0] lim);
        logic [QW-1:0] lm;
        lm = QW'(lim - DIM_W'(1));
        if (q > lm) begin
            return lm[RC_W-1:0];
        end
        return q[RC_W-1:0];
    endfunction

    assign cols_eff = clamp_dim(grid_cols_reg);
    assign rows_eff = clamp_dim(grid_rows_reg);

    assign s_id_ext = {{OBJ_W{1'b0}}, s_obj_id};
    assign id_ext   = {{OBJ_W{1'b0}}, id_reg};
    assign oth_ext  = {{OBJ_W{1'b0}}, mem_rdata};
    assign s_id_ok  = 32'(s_obj_id) < MAX_OBJECTS;
    assign oth_ok   = 32'(mem_rdata) < MAX_OBJECTS;

    assign k_p1  = {1'b0, k_reg} + (CNT_W+1)'(1);
    assign k_p2  = {1'b0, k_reg} + (CNT_W+1)'(2);
    assign cnt_x = {1'b0, cnt_reg};

    // Strict overlap of the own box against the box just read.
    assign {ax, ay, aw, ah} = own_reg;
    assign {bx, by, bw, bh} = box_rdata[4*CB-1:0];
    assign ovl = ({1'b0, ax} < {1'b0, bx} + {1'b0, bw}) &&
                 ({1'b0, ax} + {1'b0, aw} > {1'b0, bx}) &&
                 ({1'b0, ay} < {1'b0, by} + {1'b0, bh}) &&
                 ({1'b0, ay} + {1'b0, ah} > {1'b0, by});

    // Divider operands: left, right, top and bottom edge in turn.
    always_comb begin
        case (dsel_reg)
            2'd0:    div_dvd = {1'b0, nb_reg[4*CB-1:3*CB]};
            2'd1:    div_dvd = {1'b0, nb_reg[4*CB-1:3*CB]} + {1'b0, nb_reg[2*CB-1:CB]};
            2'd2:    div_dvd = {1'b0, nb_reg[3*CB-1:2*CB]};
            default: div_dvd = {1'b0, nb_reg[3*CB-1:2*CB]} + {1'b0, nb_reg[CB-1:0]};
        endcase
    end
    assign div_dvs   = (cell_size_reg == '0) ? CS_W'(1) : cell_size_reg;
    assign q_clamped = clamp_idx(div_quo, dsel_reg[1] ? rows_eff : cols_eff);

    assign box_waddr = (state_reg == S_CLEAR) ? clr_reg[OBJ_W-1:0] : id_ext[OBJ_W-1:0];
    always_comb begin
        if (state_reg == S_IDLE) begin
            box_raddr = s_id_ext[OBJ_W-1:0];
        end else if (oth_sel) begin
            box_raddr = oth_ext[OBJ_W-1:0];
        end else begin
            box_raddr = id_ext[OBJ_W-1:0];
        end
    end
    assign mem_raddr = {cell_reg, rd_slot};

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        mode_next    = mode_reg;
        id_next      = id_reg;
        nb_next      = nb_reg;
        own_next     = own_reg;
        ph_next      = ph_reg;
        cell_next    = cell_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        hit_next     = hit_reg;
        stat_next    = stat_reg;
        drop_next    = drop_reg;
        dsel_next    = dsel_reg;
        sc_next      = sc_reg;
        ec_next      = ec_reg;
        sr_next      = sr_reg;
        er_next      = er_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        num_next     = num_reg;
        m_id_next    = m_id_reg;
        m_hit_next   = m_hit_reg;
        m_stat_next  = m_stat_reg;
        we           = '0;
        box_wdata    = {1'b1, nb_reg};
        cnt_wdata    = cnt_reg - CNT_W'(1);
        mem_waddr    = {cell_reg, k_reg[SLOT_W-1:0]};
        mem_wdata    = mem_rdata;
        rd_slot      = k_p1[SLOT_W-1:0];
        oth_sel      = 1'b0;
        div_start    = 1'b0;
        nf           = 1'b0;
        pl           = 1'b0;
        nc           = 1'b0;
        adv          = 1'b0;
        place_cnt    = cnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                we.cnt    = 32'(clr_reg) < GRID_CELLS;
                we.box    = 32'(clr_reg) < MAX_OBJECTS;
                box_wdata = '0;
                cnt_wdata = '0;
                clr_next  = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_N - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    mode_next = s_mode;
                    id_next   = s_obj_id;
                    nb_next   = {s_pos_x, s_pos_y, s_size_x, s_size_y};
                    hit_next  = 1'b0;
                    drop_next = 1'b0;
                    stat_next = STAT_OK;
                    if (!s_id_ok) begin
                        stat_next  = STAT_UNKNOWN;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                cell_next = '0;
                if (mode_reg == MODE_ADD) begin
                    we.box     = 1'b1;
                    dsel_next  = 2'd0;
                    state_next = S_DIV;
                end else if (!box_rdata[BOX_W-1]) begin
                    stat_next  = STAT_UNKNOWN;
                    state_next = S_DONE;
                end else begin
                    own_next   = box_rdata[4*CB-1:0];
                    ph_next    = (mode_reg == MODE_CHECK) ? PH_CHK : PH_REM;
                    state_next = S_CNT;
                end
            end
            S_CNT: begin
                state_next = S_CNTD;
            end
            S_CNTD: begin
                cnt_next  = cnt_rdata;
                k_next    = '0;
                rd_slot   = '0;
                place_cnt = cnt_rdata;
                if (cnt_rdata == '0) begin
                    nf = 1'b1;
                end else begin
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                if (mem_rdata == id_reg) begin
                    if (ph_reg == PH_REG) begin
                        adv = 1'b1;
                    end else if (ph_reg == PH_CHK) begin
                        k_next     = '0;
                        rd_slot    = '0;
                        state_next = S_MEM;
                    end else if (k_p1 < cnt_x) begin
                        state_next = S_SHIFT;
                    end else begin
                        we.cnt = 1'b1;
                        nc     = 1'b1;
                    end
                end else if (k_p1 == cnt_x) begin
                    nf = 1'b1;
                end else begin
                    k_next = k_p1[CNT_W-1:0];
                end
            end
            S_SHIFT: begin
                // Close the gap: slot k takes the member of slot k+1.
                we.mem = 1'b1;
                if (k_p2 < cnt_x) begin
                    k_next  = k_p1[CNT_W-1:0];
                    rd_slot = k_p2[SLOT_W-1:0];
                end else begin
                    we.cnt = 1'b1;
                    nc     = 1'b1;
                end
            end
            S_MEM: begin
                oth_sel = 1'b1;
                if (mem_rdata == id_reg || !oth_ok) begin
                    if (k_p1 < cnt_x) begin
                        k_next = k_p1[CNT_W-1:0];
                    end else begin
                        nc = 1'b1;
                    end
                end else begin
                    state_next = S_BOX;
                end
            end
            S_BOX: begin
                if (ovl) begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end else if (k_p1 < cnt_x) begin
                    k_next     = k_p1[CNT_W-1:0];
                    state_next = S_MEM;
                end else begin
                    nc = 1'b1;
                end
            end
            S_DIV: begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    case (dsel_reg)
                        2'd0:    sc_next = q_clamped;
                        2'd1:    ec_next = q_clamped;
                        2'd2:    sr_next = q_clamped;
                        default: er_next = q_clamped;
                    endcase
                    dsel_next = dsel_reg + 2'd1;
                    if (dsel_reg == 2'd3) begin
                        r_next     = sr_reg;
                        c_next     = sc_reg;
                        ph_next    = PH_REG;
                        state_next = S_CELL;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_CELL: begin
                num_next   = NUM_W'(r_reg * cols_eff) + NUM_W'(c_reg);
                state_next = S_RANGE;
            end
            S_RANGE: begin
                if (32'(num_reg) >= GRID_CELLS) begin
                    adv = 1'b1;
                end else begin
                    cell_next  = num_reg[CELL_W-1:0];
                    state_next = S_CNT;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_id_next    = id_reg;
                    m_hit_next   = hit_reg;
                    m_stat_next  = stat_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Id not present in the current cell.
        if (nf) begin
            if (ph_reg == PH_REG) begin
                pl  = 1'b1;
                adv = 1'b1;
            end else begin
                nc = 1'b1;
            end
        end

        // Append the id to the current cell, or note that it was full.
        if (pl) begin
            if (place_cnt < CNT_W'(CELL_SLOTS)) begin
                we.mem    = 1'b1;
                mem_waddr = {cell_reg, place_cnt[SLOT_W-1:0]};
                mem_wdata = id_reg;
                we.cnt    = 1'b1;
                cnt_wdata = place_cnt + CNT_W'(1);
            end else begin
                drop_next = 1'b1;
            end
        end

        // Step of the sweep over all cells for remove, update and check.
        if (nc) begin
            if (cell_reg == CELL_W'(GRID_CELLS - 1)) begin
                if (ph_reg == PH_CHK || mode_reg == MODE_REMOVE) begin
                    state_next = S_DONE;
                end else begin
                    we.box     = 1'b1;
                    dsel_next  = 2'd0;
                    state_next = S_DIV;
                end
            end else begin
                cell_next  = cell_reg + CELL_W'(1);
                state_next = S_CNT;
            end
        end

        // Step over the covered rectangle of cells.
        if (adv) begin
            state_next = S_CELL;
            if (c_reg == ec_reg) begin
                c_next = sc_reg;
                if (r_reg == er_reg) begin
                    stat_next  = drop_next ? STAT_FULL : STAT_OK;
                    state_next = S_DONE;
                end else begin
                    r_next = r_reg + RC_W'(1);
                end
            end else begin
                c_next = c_reg + RC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            m_valid_reg   <= 1'b0;
            cell_size_reg <= CS_W'(32);
            grid_cols_reg <= DIM_W'(16);
            grid_rows_reg <= DIM_W'(16);
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_CELL_SIZE: cell_size_reg <= cfg_wdata;
                    CFG_GRID_COLS: grid_cols_reg <= cfg_wdata[DIM_W-1:0];
                    CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        id_reg     <= id_next;
        nb_reg     <= nb_next;
        own_reg    <= own_next;
        ph_reg     <= ph_next;
        cell_reg   <= cell_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        hit_reg    <= hit_next;
        stat_reg   <= stat_next;
        drop_reg   <= drop_next;
        dsel_reg   <= dsel_next;
        sc_reg     <= sc_next;
        ec_reg     <= ec_next;
        sr_reg     <= sr_next;
        er_reg     <= er_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        num_reg    <= num_next;
        m_id_reg   <= m_id_next;
        m_hit_reg  <= m_hit_next;
        m_stat_reg <= m_stat_next;
    end

    ugac_div #(
        .DVD_W(QW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dvd),
        .divisor (div_dvs),
        .done    (div_done),
        .quotient(div_quo)
    );

    ugac_store #(
        .BOX_W (BOX_W),
        .OBJ_W (OBJ_W),
        .CELL_W(CELL_W),
        .SLOT_W(SLOT_W),
        .CNT_W (CNT_W)
    ) u_store (
        .aclk     (aclk),
        .we       (we),
        .box_waddr(box_waddr),
        .box_wdata(box_wdata),
        .box_raddr(box_raddr),
        .box_rdata(box_rdata),
        .cnt_waddr((state_reg == S_CLEAR) ? clr_reg[CELL_W-1:0] : cell_reg),
        .cnt_wdata(cnt_wdata),
        .cnt_raddr(cell_reg),
        .cnt_rdata(cnt_rdata),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_result_id = m_id_reg;
    assign m_hit       = m_hit_reg;
    assign m_status    = m_stat_reg;
endmodule
`default_nettype wire

// ===== sv/ugac_checker.sv =====
`default_nettype none
module ugac_checker
    import ugac_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_hit,
    input wire logic [1:0] m_status
);
    // A pending result stays offered until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before it was taken");

    // A hit only comes from a successful check.
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_status == STAT_OK)
        else $error("hit reported with a failing status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("undefined status code");

    // One item at a time: the input closes right after an accept.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");
endmodule

bind uniform_grid_aabb_collision ugac_checker u_ugac_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_hit   (m_hit),
    .m_status(m_status)
);
`default_nettype wire
